// ----- rtl/slt_pkg.sv -----
package slt_pkg;

  // Default sizes
  localparam int MAX_LINES_DEF    = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Fixed port widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 16;
  localparam int PAY_W    = 32;
  localparam int STATUS_W = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_STORE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST  = 2'd2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_REPLACED = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DELETED  = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_CLEARED  = 3'd4,
    ST_LIST     = 3'd5
  } status_t;

  // Outcome of the shared key comparator
  typedef struct packed {
    logic eq;
    logic ge;
  } key_cmp_t;

endpackage

// ----- rtl/slt_ram.sv -----
module slt_ram #(
  parameter int DEPTH = slt_pkg::MAX_LINES_DEF,
  parameter int WIDTH = slt_pkg::KEY_W + slt_pkg::PAYLOAD_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/slt_keycmp.sv -----
module slt_keycmp (
  input  logic [slt_pkg::KEY_W-1:0] entry_key,
  input  logic [slt_pkg::KEY_W-1:0] probe_key,
  output slt_pkg::key_cmp_t         res
);
  import slt_pkg::*;

  // Compare a stored key against the key being searched for
  assign res.eq = (entry_key == probe_key);
  assign res.ge = (entry_key >= probe_key);

endmodule

// ----- rtl/sorted_keyed_line_table_core.sv -----
// Channel  | Handshake           | Word
// ---------+---------------------+---------------------------------------------------
// in       | in_valid / in_stall | in_op, in_line_number, in_payload, in_is_empty
// out      | out_valid/out_stall | out_status, out_line_number_res, out_payload_res,
//          |                     | out_present, out_last
//
// One item at a time; the entries live in a single memory with one write and one
// registered read port, and one key comparator serves the search.
// Store: search stops at the first key not below the new one and the shift moves only
// those above it, up for an insert and down for a delete.
// List: one result per cycle from the read port while out_stall is low; others give one.
// Reset empties the table at once; output stalls hold the sequencer, not the table.
module sorted_keyed_line_table_core #(
  parameter int MAX_LINES    = slt_pkg::MAX_LINES_DEF,
  parameter int PAYLOAD_BITS = slt_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [slt_pkg::OP_W-1:0]      in_op,
  input  logic [slt_pkg::KEY_W-1:0]     in_line_number,
  input  logic [slt_pkg::PAY_W-1:0]     in_payload,
  input  logic                          in_is_empty,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [slt_pkg::STATUS_W-1:0]  out_status,
  output logic [slt_pkg::KEY_W-1:0]     out_line_number_res,
  output logic [slt_pkg::PAY_W-1:0]     out_payload_res,
  output logic                          out_present,
  output logic                          out_last
);
  import slt_pkg::*;

  localparam int CW = $clog2(MAX_LINES + 1);
  localparam int IW = $clog2(MAX_LINES);
  localparam int EW = KEY_W + PAYLOAD_BITS;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_DEL    = 7'b0001000,
    S_INS    = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_LIST   = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    cv_r, cv_nxt;
  logic                    mv_v_r, mv_v_nxt;
  logic [CW-1:0]           cidx_r, cidx_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic                    match_r, match_nxt;
  logic [IW-1:0]           mv_dst_r, mv_dst_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic                    empty_r, empty_nxt;
  status_t                 status_r, status_nxt;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [KEY_W-1:0]        out_key_r;
  logic [PAY_W-1:0]        out_pay_r;
  logic                    out_present_r;
  logic                    out_last_r;

  logic                    out_load;
  status_t                 ld_status;
  logic [KEY_W-1:0]        ld_key;
  logic [PAY_W-1:0]        ld_pay;
  logic                    ld_present;
  logic                    ld_last;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [EW-1:0]           ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [EW-1:0]           ram_rdata;

  logic [KEY_W-1:0]        rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [63:0]             rd_pay_ext;
  logic [63:0]             in_pay_ext;
  logic [CW-1:0]           idx_inc;
  logic [CW-1:0]           idx_dec;
  logic                    in_accept;
  logic                    out_free;
  key_cmp_t                cmp;

  // Split the stored word and size the payloads
  assign rd_key     = ram_rdata[EW-1 -: KEY_W];
  assign rd_pay     = ram_rdata[PAYLOAD_BITS-1:0];
  assign rd_pay_ext = 64'(rd_pay);
  assign in_pay_ext = 64'(in_payload);
  assign idx_inc    = idx_r + 1'b1;
  assign idx_dec    = idx_r - 1'b1;

  // Handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  slt_ram #(
    .DEPTH (MAX_LINES),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slt_keycmp u_cmp (
    .entry_key (rd_key),
    .probe_key (key_r),
    .res       (cmp)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    cv_nxt     = cv_r;
    mv_v_nxt   = mv_v_r;
    cidx_nxt   = cidx_r;
    pos_nxt    = pos_r;
    match_nxt  = match_r;
    mv_dst_nxt = mv_dst_r;
    key_nxt    = key_r;
    pay_nxt    = pay_r;
    empty_nxt  = empty_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = {key_r, pay_r};
    ram_raddr  = '0;
    out_load   = 1'b0;
    ld_status  = status_r;
    ld_key     = key_r;
    ld_pay     = '0;
    ld_present = 1'b0;
    ld_last    = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        // Take an item; the read port already fetches entry zero for a list
        if (in_accept) begin
          key_nxt   = in_line_number;
          pay_nxt   = in_pay_ext[PAYLOAD_BITS-1:0];
          empty_nxt = in_is_empty;
          idx_nxt   = '0;
          cv_nxt    = 1'b0;
          unique case (in_op)
            OP_STORE: begin
              state_nxt = S_SEARCH;
            end
            OP_CLEAR: begin
              cnt_nxt    = '0;
              status_nxt = ST_CLEARED;
              state_nxt  = S_FIN;
            end
            OP_LIST: begin
              status_nxt = ST_LIST;
              state_nxt  = (cnt_r == '0) ? S_FIN : S_LIST;
            end
            default: begin
              status_nxt = ST_IGNORED;
              state_nxt  = S_FIN;
            end
          endcase
        end
      end

      S_SEARCH: begin
        // Issue one read a cycle and compare each word that the registered read port returns
        if (idx_r < cnt_r) begin
          ram_raddr = idx_r[IW-1:0];
          cidx_nxt  = idx_r;
          cv_nxt    = 1'b1;
          idx_nxt   = idx_inc;
        end else begin
          cv_nxt = 1'b0;
        end
        if (cv_r && cmp.ge) begin
          pos_nxt   = cidx_r;
          match_nxt = cmp.eq;
          state_nxt = S_DECIDE;
        end else if (!cv_r && !(idx_r < cnt_r)) begin
          pos_nxt   = cnt_r;
          match_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        mv_v_nxt = 1'b0;
        if (match_r && !empty_r) begin
          ram_we     = 1'b1;
          ram_waddr  = pos_r[IW-1:0];
          status_nxt = ST_REPLACED;
          state_nxt  = S_FIN;
        end else if (match_r) begin
          idx_nxt    = pos_r + 1'b1;
          status_nxt = ST_DELETED;
          state_nxt  = S_DEL;
        end else if (!empty_r && (cnt_r != CW'(MAX_LINES))) begin
          idx_nxt    = cnt_r;
          status_nxt = ST_INSERTED;
          state_nxt  = S_INS;
        end else begin
          status_nxt = ST_IGNORED;
          state_nxt  = S_FIN;
        end
      end

      S_DEL: begin
        // Move each entry above the gap down by one
        if (idx_r < cnt_r) begin
          ram_raddr  = idx_r[IW-1:0];
          mv_dst_nxt = idx_dec[IW-1:0];
          mv_v_nxt   = 1'b1;
          idx_nxt    = idx_inc;
        end else begin
          mv_v_nxt = 1'b0;
        end
        if (mv_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = mv_dst_r;
          ram_wdata = ram_rdata;
        end
        if (!mv_v_r && !(idx_r < cnt_r)) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_INS: begin
        // Move larger entries up by one from the top, then drop the new one in
        if (idx_r > pos_r) begin
          ram_raddr  = idx_dec[IW-1:0];
          mv_dst_nxt = idx_r[IW-1:0];
          mv_v_nxt   = 1'b1;
          idx_nxt    = idx_dec;
        end else begin
          mv_v_nxt = 1'b0;
        end
        if (mv_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = mv_dst_r;
          ram_wdata = ram_rdata;
        end
        if (!mv_v_r && !(idx_r > pos_r)) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[IW-1:0];
          ram_wdata = {key_r, pay_r};
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // Hand the single result word to the output register
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = status_r;
          ld_key    = ((status_r == ST_CLEARED) || (status_r == ST_LIST)) ? '0 : key_r;
          state_nxt = S_IDLE;
        end
      end

      S_LIST: begin
        // Read port holds entry idx; fetch the next one as this one leaves
        ram_raddr = idx_r[IW-1:0];
        if (out_free) begin
          out_load   = 1'b1;
          ld_status  = ST_LIST;
          ld_key     = rd_key;
          ld_pay     = rd_pay_ext[PAY_W-1:0];
          ld_present = 1'b1;
          ld_last    = (idx_inc == cnt_r);
          ram_raddr  = idx_inc[IW-1:0];
          idx_nxt    = idx_inc;
          if (idx_inc == cnt_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      cv_r    <= 1'b0;
      mv_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      cv_r    <= cv_nxt;
      mv_v_r  <= mv_v_nxt;
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    cidx_r   <= cidx_nxt;
    pos_r    <= pos_nxt;
    match_r  <= match_nxt;
    mv_dst_r <= mv_dst_nxt;
    key_r    <= key_nxt;
    pay_r    <= pay_nxt;
    empty_r  <= empty_nxt;
    status_r <= status_nxt;
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= ld_status;
      out_key_r     <= ld_key;
      out_pay_r     <= ld_pay;
      out_present_r <= ld_present;
      out_last_r    <= ld_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_line_number_res = out_key_r;
  assign out_payload_res     = out_pay_r;
  assign out_present         = out_present_r;
  assign out_last            = out_last_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_LINES))
    else $error("entry count above table size");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before the first finished");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_LIST) |-> out_last)
    else $error("non-list result without last mark");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("table written while idle");

endmodule
